// ----- rtl/wuf_pkg.sv -----
// shared types and constants for the websocket frame unmasker
package wuf_pkg;

    typedef enum logic [1:0] {
        STATUS_PAYLOAD     = 2'd0,
        STATUS_EMPTY_FRAME = 2'd1,
        STATUS_UNSUPPORTED = 2'd2
    } status_t;

    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
    localparam logic [15:0] KEY_LAST_COUNT = 16'd3;

    typedef struct packed {
        logic [7:0]  payload_byte;
        status_t     status;
        logic        last_of_frame;
        logic [3:0]  frame_opcode;
        logic        fin_flag;
        logic [15:0] byte_index;
    } result_t;

endpackage

// ----- rtl/wuf_parser.sv -----
// frame header parser, key capture and payload unmasking for one request
module wuf_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             byte_valid,
    input  logic [7:0]       rx_byte,
    output logic             res_valid,
    output wuf_pkg::result_t res
);
    import wuf_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT_HI  = 3'd2,
        PH_EXT_LO  = 3'd3,
        PH_KEY     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_SKIP    = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        masked_reg, masked_next;
    logic [15:0] length_reg, length_next;
    logic [31:0] key_reg, key_next;
    logic [15:0] count_reg, count_next;

    logic [6:0]  len_code;
    logic [15:0] count_inc;
    logic [7:0]  key_byte;
    logic        payload_last;

    assign len_code     = rx_byte[6:0];
    assign count_inc    = count_reg + 16'd1;
    assign payload_last = (count_inc == length_reg);

    always_comb begin
        case (count_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next  = phase_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        masked_next = masked_reg;
        length_next = length_reg;
        key_next    = key_reg;
        count_next  = count_reg;
        res_valid   = 1'b0;
        res.payload_byte  = 8'd0;
        res.status        = STATUS_PAYLOAD;
        res.last_of_frame = 1'b0;
        res.frame_opcode  = opcode_reg;
        res.fin_flag      = fin_reg;
        res.byte_index    = 16'd0;

        case (phase_reg)
            PH_HDR1: begin
                masked_next = rx_byte[7];
                if (len_code == LEN_CODE_EXT64) begin
                    phase_next        = PH_HDR0;
                    res_valid         = 1'b1;
                    res.status        = STATUS_UNSUPPORTED;
                    res.last_of_frame = 1'b1;
                end else if (len_code == LEN_CODE_EXT16) begin
                    phase_next = PH_EXT_HI;
                end else begin
                    length_next = {9'd0, len_code};
                    count_next  = 16'd0;
                    if (rx_byte[7]) begin
                        phase_next = PH_KEY;
                    end else if (len_code == 7'd0) begin
                        phase_next = PH_HDR0;
                    end else begin
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_EXT_HI: begin
                length_next = {rx_byte, 8'd0};
                phase_next  = PH_EXT_LO;
            end
            PH_EXT_LO: begin
                length_next = {length_reg[15:8], rx_byte};
                count_next  = 16'd0;
                if (masked_reg) begin
                    phase_next = PH_KEY;
                end else if ({length_reg[15:8], rx_byte} == 16'd0) begin
                    phase_next = PH_HDR0;
                end else begin
                    phase_next = PH_SKIP;
                end
            end
            PH_KEY: begin
                key_next   = {key_reg[23:0], rx_byte};
                count_next = count_inc;
                if (count_reg == KEY_LAST_COUNT) begin
                    count_next = 16'd0;
                    if (length_reg == 16'd0) begin
                        phase_next        = PH_HDR0;
                        res_valid         = 1'b1;
                        res.status        = STATUS_EMPTY_FRAME;
                        res.last_of_frame = 1'b1;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                res_valid         = 1'b1;
                res.payload_byte  = rx_byte ^ key_byte;
                res.last_of_frame = payload_last;
                res.byte_index    = count_reg;
                count_next        = count_inc;
                if (payload_last) begin
                    phase_next = PH_HDR0;
                end
            end
            PH_SKIP: begin
                count_next = count_inc;
                if (payload_last) begin
                    phase_next = PH_HDR0;
                end
            end
            default: begin
                fin_next    = rx_byte[7];
                opcode_next = rx_byte[3:0];
                phase_next  = PH_HDR1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR0;
            fin_reg    <= 1'b0;
            opcode_reg <= 4'd0;
            masked_reg <= 1'b0;
            length_reg <= 16'd0;
            key_reg    <= 32'd0;
            count_reg  <= 16'd0;
        end else if (byte_valid) begin
            phase_reg  <= phase_next;
            fin_reg    <= fin_next;
            opcode_reg <= opcode_next;
            masked_reg <= masked_next;
            length_reg <= length_next;
            key_reg    <= key_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/websocket_frame_unmasker.sv -----
// Receive-side WebSocket frame unmasker. One byte of the frame stream is taken
// per request, one per cycle while m_ready stays high; a result is registered
// from the byte that causes it and held in the output register. Header
// bytes, extended length and masking key bytes give no result; each payload
// byte of a masked frame gives one unmasked byte, a masked empty frame gives
// one empty-frame result and a 64-bit length code gives an unsupported result.
// Unmasked frames are skipped. A new byte is taken in the same cycle the held
// result is taken, so the rate is set only by the output register handshake.
module websocket_frame_unmasker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_rx_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_payload_byte,
    output logic [1:0]            m_status,
    output logic                  m_last_of_frame,
    output logic [3:0]            m_frame_opcode,
    output logic                  m_fin_flag,
    output logic [15:0]           m_byte_index
);
    import wuf_pkg::*;

    logic    accept;
    logic    res_valid;
    result_t res;
    logic    m_valid_reg, m_valid_next;
    result_t result_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    wuf_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (accept),
        .rx_byte    (s_rx_byte),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = res_valid;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            result_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_payload_byte  = result_reg.payload_byte;
    assign m_status        = result_reg.status;
    assign m_last_of_frame = result_reg.last_of_frame;
    assign m_frame_opcode  = result_reg.frame_opcode;
    assign m_fin_flag      = result_reg.fin_flag;
    assign m_byte_index    = result_reg.byte_index;

endmodule

// ----- tb/sv/websocket_frame_unmasker_tb.sv -----
// testbench for the websocket frame unmasker: directed and random frame streams
`timescale 1ns / 1ps

module websocket_frame_unmasker_tb;
    import wuf_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 320;

    typedef enum logic [2:0] {
        ST_HEADER,
        ST_LENGTH,
        ST_EXT_HI,
        ST_EXT_LO,
        ST_KEY,
        ST_DATA,
        ST_SKIP
    } parse_state_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_payload_byte;
    logic [1:0]  m_status;
    logic        m_last_of_frame;
    logic [3:0]  m_frame_opcode;
    logic        m_fin_flag;
    logic [15:0] m_byte_index;

    parse_state_t phase = ST_HEADER;
    logic         hold_fin = 1'b0;
    logic [3:0]   hold_opcode = 4'd0;
    logic         hold_masked = 1'b0;
    logic [15:0]  frame_len = 16'd0;
    logic [31:0]  mask_key = 32'd0;
    logic [15:0]  byte_count = 16'd0;

    result_t frame_results_due[$];
    int      errors = 0;
    int      items_sent = 0;
    int      idle_cycles = 0;
    bit      no_gaps = 1'b0;

    websocket_frame_unmasker dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload_byte  (m_payload_byte),
        .m_status        (m_status),
        .m_last_of_frame (m_last_of_frame),
        .m_frame_opcode  (m_frame_opcode),
        .m_fin_flag      (m_fin_flag),
        .m_byte_index    (m_byte_index)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    function automatic void emit_result(input logic [7:0] data, input status_t st,
                                        input logic last, input logic [15:0] index);
        result_t r;
        r.payload_byte  = data;
        r.status        = st;
        r.last_of_frame = last;
        r.frame_opcode  = hold_opcode;
        r.fin_flag      = hold_fin;
        r.byte_index    = index;
        frame_results_due.push_back(r);
    endfunction

    function automatic void enter_body();
        byte_count = 16'd0;
        if (hold_masked) begin
            phase = ST_KEY;
        end else if (frame_len == 16'd0) begin
            phase = ST_HEADER;
        end else begin
            phase = ST_SKIP;
        end
    endfunction

    function automatic void predict_unmask(input logic [7:0] b);
        logic [6:0] code;
        logic [7:0] kb;
        logic       is_last;
        case (phase)
            ST_LENGTH: begin
                hold_masked = b[7];
                code = b[6:0];
                if (code == LEN_CODE_EXT64) begin
                    phase = ST_HEADER;
                    emit_result(8'd0, STATUS_UNSUPPORTED, 1'b1, 16'd0);
                end else if (code == LEN_CODE_EXT16) begin
                    phase = ST_EXT_HI;
                end else begin
                    frame_len = {9'd0, code};
                    enter_body();
                end
            end
            ST_EXT_HI: begin
                frame_len = {b, 8'd0};
                phase = ST_EXT_LO;
            end
            ST_EXT_LO: begin
                frame_len = {frame_len[15:8], b};
                enter_body();
            end
            ST_KEY: begin
                mask_key = {mask_key[23:0], b};
                if (byte_count == KEY_LAST_COUNT) begin
                    byte_count = 16'd0;
                    if (frame_len == 16'd0) begin
                        phase = ST_HEADER;
                        emit_result(8'd0, STATUS_EMPTY_FRAME, 1'b1, 16'd0);
                    end else begin
                        phase = ST_DATA;
                    end
                end else begin
                    byte_count = byte_count + 16'd1;
                end
            end
            ST_DATA: begin
                kb = 8'(mask_key >> (24 - 8 * int'(byte_count[1:0])));
                is_last = (byte_count + 16'd1) == frame_len;
                emit_result(b ^ kb, STATUS_PAYLOAD, is_last, byte_count);
                byte_count = byte_count + 16'd1;
                if (is_last) begin
                    phase = ST_HEADER;
                end
            end
            ST_SKIP: begin
                byte_count = byte_count + 16'd1;
                if (byte_count == frame_len) begin
                    phase = ST_HEADER;
                end
            end
            default: begin
                hold_fin = b[7];
                hold_opcode = b[3:0];
                phase = ST_LENGTH;
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_unmask(b);
        items_sent++;
    endtask

    task automatic send_frame(input logic [7:0] hdr, input logic masked,
                              input logic [15:0] len, input logic ext);
        send_byte(hdr);
        if (ext || len > 16'd125) begin
            send_byte({masked, LEN_CODE_EXT16});
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end else begin
            send_byte({masked, len[6:0]});
        end
        if (masked) begin
            repeat (4) send_byte(8'($urandom));
        end
        repeat (len) send_byte(8'($urandom));
    endtask

    task automatic wait_results_drained();
        while (frame_results_due.size() != 0) @(posedge aclk);
    endtask

    task automatic compare_field(input string fname, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t mismatch %s: expected %0h actual %0h", $time, fname, want, got);
        end
    endtask

    task automatic test_masked_payload();
        send_byte(8'hF9);
        send_byte(8'h85);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h3C);
        send_byte(8'hC3);
        send_byte(8'h80);
    endtask

    task automatic test_empty_frame();
        send_byte(8'h00);
        send_byte(8'h80);
        repeat (4) send_byte(8'hFF);
    endtask

    task automatic test_unsupported_length();
        send_byte(8'h8F);
        send_byte(8'hFF);
        send_byte(8'h02);
        send_byte(8'h7F);
        // trailing bytes of the dropped frame parse as a new header
        send_byte(8'h81);
        send_byte(8'h00);
    endtask

    task automatic test_unmasked_frames();
        send_byte(8'h82);
        send_byte(8'h02);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_byte(8'h01);
        send_byte(8'h7E);
        send_byte(8'h00);
        send_byte(8'h00);
    endtask

    task automatic test_drain_pause();
        send_frame(8'($urandom), 1'b1, 16'd6, 1'b0);
        @(negedge aclk);
        s_valid <= 1'b0;
        wait_results_drained();
        send_frame(8'($urandom), 1'b1, 16'd3, 1'b1);
    endtask

    task automatic test_long_frame();
        logic [15:0] len;
        len = 16'(256 + $urandom_range(0, 40));
        send_frame(8'($urandom), 1'b1, len, 1'b1);
    endtask

    task automatic test_random_frames();
        int start;
        int pick;
        int n;
        logic [15:0] len;
        logic ext;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                n = $urandom_range(1, 6);
                repeat (n) send_byte(phase == ST_EXT_HI ? 8'h00 : 8'($urandom));
                while (phase != ST_HEADER) begin
                    send_byte(phase == ST_EXT_HI ? 8'h00 : 8'($urandom));
                end
            end else if (pick < 18) begin
                send_byte(8'($urandom));
                send_byte({1'($urandom), LEN_CODE_EXT64});
            end else begin
                ext = ($urandom_range(0, 9) == 0);
                if (ext) begin
                    len = 16'($urandom_range(0, 40));
                end else if ($urandom_range(0, 5) == 0) begin
                    len = 16'($urandom_range(21, 125));
                end else begin
                    len = 16'($urandom_range(0, 20));
                end
                send_frame(8'($urandom), pick >= 40, len, ext);
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_rx_byte = 8'd0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_masked_payload();
        test_empty_frame();
        test_unsupported_length();
        test_unmasked_frames();
        test_drain_pause();
        test_long_frame();
        test_random_frames();

        @(negedge aclk);
        s_valid <= 1'b0;
        wait_results_drained();
        repeat (8) @(posedge aclk);
        if (errors == 0 && frame_results_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            stall = no_gaps ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (frame_results_due.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none actual status %0h byte %0h",
                         $time, m_status, m_payload_byte);
            end else begin
                want = frame_results_due.pop_front();
                compare_field("payload_byte", 16'(want.payload_byte), 16'(m_payload_byte));
                compare_field("status", 16'(want.status), 16'(m_status));
                compare_field("last_of_frame", 16'(want.last_of_frame), 16'(m_last_of_frame));
                compare_field("frame_opcode", 16'(want.frame_opcode), 16'(m_frame_opcode));
                compare_field("fin_flag", 16'(want.fin_flag), 16'(m_fin_flag));
                compare_field("byte_index", want.byte_index, m_byte_index);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t watchdog: no request moved for %0d cycles", $time, idle_cycles);
            $display("status: fail");
            $finish;
        end
    end

endmodule
